FILE: hw/rtl/vm_instruction_execute_core_top_macros.svh
// Assertion macros used by the core's top-level RTL file.
`ifndef VM_INSTRUCTION_EXECUTE_CORE_TOP_MACROS_SVH
`define VM_INSTRUCTION_EXECUTE_CORE_TOP_MACROS_SVH

// A condition that implies a consequence in the same cycle.
`define VMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that implies a consequence in the following cycle.
`define VMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/vmx_pkg.sv
// Types, constants and helpers of the instruction execute core.
`timescale 1ns / 1ps

package vmx_pkg;

  // Sizes of the machine.
  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = 12;
  localparam int STACK_LIMIT = 15;
  localparam int STACK_AW    = 4;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int ROW_AW      = 5;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'd80;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_EXEC = 2'd0,
    MODE_MWR  = 2'd1,
    MODE_MRD  = 2'd2,
    MODE_ROW  = 2'd3
  } mode_t;

  // Fault codes.
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_INVAL = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_UNDER = 2'd3
  } fault_t;

  // Top nibble of the instruction word.
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEB  = 4'h3;
  localparam logic [3:0] OP_SNEB = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDB  = 4'h6;
  localparam logic [3:0] OP_ADDB = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // System sub-codes.
  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  // ALU sub-codes.
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Key sub-codes.
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  // Miscellaneous sub-codes.
  localparam logic [7:0] F_GETDT = 8'h07;
  localparam logic [7:0] F_WKEY  = 8'h0A;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STR   = 8'h55;
  localparam logic [7:0] F_LDR   = 8'h65;

  // Sequencer states.
  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_DEC    = 15'h0002,
    S_RDA    = 15'h0004,
    S_RDB    = 15'h0008,
    S_EXE    = 15'h0010,
    S_WRX    = 15'h0020,
    S_STK    = 15'h0040,
    S_SPR_RD = 15'h0080,
    S_SPR_WR = 15'h0100,
    S_SPR_VF = 15'h0200,
    S_BLK_RD = 15'h0400,
    S_BLK_WR = 15'h0800,
    S_MRD    = 15'h1000,
    S_FRD    = 15'h2000,
    S_FIN    = 15'h4000
  } state_t;

  // One decimal digit of a byte: 0 hundreds, 1 tens, 2 ones.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  hun;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;
    logic [7:0]  one;
    hun  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem  = v - 8'(hun * 7'd100);
    prod = 15'(rem[6:0] * 8'd205);
    ten  = prod[14:11];
    one  = rem - 8'(ten * 4'd10);
    unique case (pos)
      2'd0:    bcd_digit = {6'd0, hun};
      2'd1:    bcd_digit = {4'd0, ten};
      default: bcd_digit = one;
    endcase
  endfunction

endpackage

FILE: hw/rtl/vm_instruction_execute_core_top.sv
// Top level of the instruction execute core: sequencer and its memories.
`timescale 1ns / 1ps
`include "vm_instruction_execute_core_top_macros.svh"

// Executes one instruction word (or one memory or display access) per input beat and returns
// one result beat with pc, index, VF, read data, fault code, halt and sound status. State lives
// in synchronous memories (byte memory, register file, display rows, return stack) that the
// sequencer reads, modifies and writes back, one access per port and cycle. A plain instruction
// passes decode, operand reads, execute and finish; a sprite adds a read and a write per drawn row,
// a block load, store or BCD a read and a write per register or digit (up to 16 registers), as
// each memory has one read and one write port. CLS marks all rows unwritten. A new beat is
// taken once the previous result sits in the output register, held until the receiver takes it.
module vm_instruction_execute_core_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  input  logic [11:0] in_mem_address,
  input  logic [7:0]  in_mem_byte,
  input  logic [4:0]  in_row_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_next_pc,
  output logic [15:0] out_index_value,
  output logic [7:0]  out_flag_value,
  output logic [63:0] out_read_value,
  output logic [1:0]  out_fault_code,
  output logic        out_halted,
  output logic        out_sound_on
);
  import vmx_pkg::*;

  // Sequencer and architectural registers.
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [15:0] op_r, op_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic [7:0]  rnd_r, rnd_nxt;
  logic [11:0] maddr_r, maddr_nxt;
  logic [7:0]  mbyte_r, mbyte_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [7:0]  a_r, a_nxt, b_r, b_nxt, wx_r, wx_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [STACK_AW-1:0] sp_r, sp_nxt;
  logic [7:0]  dt_r, dt_nxt, st_r, st_nxt, vf_r, vf_nxt;
  logic        halt_r, halt_nxt;
  logic [11:0] font_r;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        hit_r, hit_nxt;
  logic [63:0] rd_r, rd_nxt;
  fault_t      fault_r, fault_nxt;

  // Output register.
  logic        out_valid_r;
  logic [11:0] out_pc_r;
  logic [15:0] out_i_r;
  logic [7:0]  out_vf_r;
  logic [63:0] out_rd_r;
  fault_t      out_fault_r;
  logic        out_halt_r, out_snd_r;
  logic        out_load;

  // Memory ports.
  logic [7:0]        mem_ram [MEM_BYTES];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_q_r;

  logic [7:0]  rf_ram [16];
  logic [15:0] rf_vld_r;
  logic        rf_we, rf_vq_r;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [7:0]  rf_wdata, rf_q_r, rf_rdata;

  logic [SCREEN_W-1:0] frm_ram [SCREEN_H];
  logic [SCREEN_H-1:0] frm_vld_r;
  logic                frm_we, frm_clr, frm_vq_r;
  logic [ROW_AW-1:0]   frm_waddr, frm_raddr;
  logic [SCREEN_W-1:0] frm_wdata, frm_q_r, frm_rdata;

  logic [11:0]         stk_ram [STACK_LIMIT];
  logic                stk_we;
  logic [STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [11:0]         stk_wdata, stk_q_r;

  // Instruction fields and derived values.
  logic [3:0]  f_hi, f_x, f_y, f_n;
  logic [11:0] f_nnn;
  logic [7:0]  f_kk;
  logic [11:0] pc_adv, pc_skip;
  logic [5:0]  spr_y;
  logic [63:0] spr_row;
  logic [11:0] blk_addr;
  logic [3:0]  blk_last;
  logic [3:0]  key_idx;
  logic        key_any, key_down;
  logic [8:0]  sum9;
  logic        flt;
  fault_t      flt_code;

  assign f_hi  = op_r[15:12];
  assign f_x   = op_r[11:8];
  assign f_y   = op_r[7:4];
  assign f_n   = op_r[3:0];
  assign f_nnn = op_r[11:0];
  assign f_kk  = op_r[7:0];

  assign pc_adv   = pc_r + 12'd2;
  assign pc_skip  = pc_r + 12'd4;
  assign spr_y    = {1'b0, b_r[4:0]} + {2'b00, cnt_r};
  assign spr_row  = {mem_q_r, 56'd0} >> a_r[5:0];
  assign blk_addr = i_r[11:0] + {8'd0, cnt_r};
  assign blk_last = (f_kk == F_BCD) ? 4'd2 : f_x;
  assign key_down = (a_r < 8'd16) && keys_r[a_r[3:0]];
  assign sum9     = {1'b0, a_r} + {1'b0, b_r};
  assign key_any  = |keys_r;

  // Unwritten register-file entries and display rows read as zero.
  assign rf_rdata  = rf_vq_r ? rf_q_r : 8'h00;
  assign frm_rdata = frm_vq_r ? frm_q_r : '0;
  assign stk_raddr = sp_r - 4'd1;

  // Lowest pressed key.
  always_comb begin
    key_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) key_idx = 4'(k);
    end
  end

  // Sequencer next state, memory port control and register updates.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    op_nxt    = op_r;
    keys_nxt  = keys_r;
    rnd_nxt   = rnd_r;
    maddr_nxt = maddr_r;
    mbyte_nxt = mbyte_r;
    row_nxt   = row_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    wx_nxt    = wx_r;
    pc_nxt    = pc_r;
    i_nxt     = i_r;
    sp_nxt    = sp_r;
    dt_nxt    = dt_r;
    st_nxt    = st_r;
    halt_nxt  = halt_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    rd_nxt    = rd_r;
    fault_nxt = fault_r;
    out_load  = 1'b0;
    flt       = 1'b0;
    flt_code  = FAULT_NONE;

    mem_we    = 1'b0;
    mem_waddr = blk_addr;
    mem_wdata = rf_rdata;
    mem_raddr = blk_addr;
    rf_we     = 1'b0;
    rf_waddr  = f_x;
    rf_wdata  = wx_r;
    rf_raddr  = f_x;
    frm_we    = 1'b0;
    frm_clr   = 1'b0;
    frm_waddr = spr_y[ROW_AW-1:0];
    frm_wdata = frm_rdata ^ spr_row;
    frm_raddr = spr_y[ROW_AW-1:0];
    stk_we    = 1'b0;
    stk_waddr = sp_r;
    stk_wdata = pc_adv;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = mode_t'(in_mode);
          op_nxt    = in_opcode;
          keys_nxt  = in_keys_down;
          rnd_nxt   = in_random_byte;
          maddr_nxt = in_mem_address;
          mbyte_nxt = in_mem_byte;
          row_nxt   = in_row_select;
          rd_nxt    = '0;
          fault_nxt = FAULT_NONE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (mode_r)
          MODE_EXEC: begin
            rf_raddr  = f_x;
            state_nxt = halt_r ? S_FIN : S_RDA;
          end
          MODE_MWR: begin
            mem_we    = 1'b1;
            mem_waddr = maddr_r;
            mem_wdata = mbyte_r;
            state_nxt = S_FIN;
          end
          MODE_MRD: begin
            mem_raddr = maddr_r;
            state_nxt = S_MRD;
          end
          MODE_ROW: begin
            frm_raddr = row_r;
            state_nxt = S_FRD;
          end
        endcase
      end
      S_MRD: begin
        rd_nxt    = {56'd0, mem_q_r};
        state_nxt = S_FIN;
      end
      S_FRD: begin
        rd_nxt    = ({1'b0, row_r} < 6'(SCREEN_H)) ? frm_rdata : '0;
        state_nxt = S_FIN;
      end
      S_RDA: begin
        a_nxt     = rf_rdata;
        rf_raddr  = (f_hi == OP_JPV0) ? 4'h0 : f_y;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        b_nxt     = rf_rdata;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        pc_nxt    = pc_adv;
        state_nxt = S_FIN;
        cnt_nxt   = 4'd0;
        hit_nxt   = 1'b0;
        unique case (f_hi)
          OP_SYS: begin
            if (f_x == 4'h0 && f_kk == SYS_CLS) begin
              frm_clr = 1'b1;
            end else if (f_x == 4'h0 && f_kk == SYS_RET) begin
              if (sp_r == '0) begin
                flt      = 1'b1;
                flt_code = FAULT_UNDER;
              end else begin
                state_nxt = S_STK;
              end
            end else begin
              flt      = 1'b1;
              flt_code = FAULT_INVAL;
            end
          end
          OP_JP: pc_nxt = f_nnn;
          OP_CALL: begin
            if (sp_r >= STACK_AW'(STACK_LIMIT)) begin
              flt      = 1'b1;
              flt_code = FAULT_OVER;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + 4'd1;
              pc_nxt = f_nnn;
            end
          end
          OP_SEB:  if (a_r == f_kk) pc_nxt = pc_skip;
          OP_SNEB: if (a_r != f_kk) pc_nxt = pc_skip;
          OP_SER:  if (a_r == b_r) pc_nxt = pc_skip;
          OP_SNER: if (a_r != b_r) pc_nxt = pc_skip;
          OP_LDB: begin
            rf_we    = 1'b1;
            rf_wdata = f_kk;
          end
          OP_ADDB: begin
            rf_we    = 1'b1;
            rf_wdata = a_r + f_kk;
          end
          OP_ALU: begin
            // Flag-setting operations write VF now and Vx in the next cycle.
            rf_waddr = 4'hF;
            case (f_n)
              ALU_MOV: begin
                rf_we = 1'b1; rf_waddr = f_x; rf_wdata = b_r;
              end
              ALU_OR: begin
                rf_we = 1'b1; rf_waddr = f_x; rf_wdata = a_r | b_r;
              end
              ALU_AND: begin
                rf_we = 1'b1; rf_waddr = f_x; rf_wdata = a_r & b_r;
              end
              ALU_XOR: begin
                rf_we = 1'b1; rf_waddr = f_x; rf_wdata = a_r ^ b_r;
              end
              ALU_ADD: begin
                rf_we = 1'b1; rf_wdata = {7'd0, sum9[8]};
                wx_nxt = sum9[7:0]; state_nxt = S_WRX;
              end
              ALU_SUB: begin
                rf_we = 1'b1; rf_wdata = {7'd0, a_r >= b_r};
                wx_nxt = a_r - b_r; state_nxt = S_WRX;
              end
              ALU_SHR: begin
                rf_we = 1'b1; rf_wdata = {7'd0, a_r[0]};
                wx_nxt = {1'b0, a_r[7:1]}; state_nxt = S_WRX;
              end
              ALU_SUBN: begin
                rf_we = 1'b1; rf_wdata = {7'd0, b_r >= a_r};
                wx_nxt = b_r - a_r; state_nxt = S_WRX;
              end
              ALU_SHL: begin
                rf_we = 1'b1; rf_wdata = {7'd0, a_r[7]};
                wx_nxt = {a_r[6:0], 1'b0}; state_nxt = S_WRX;
              end
              default: begin
                flt      = 1'b1;
                flt_code = FAULT_INVAL;
              end
            endcase
          end
          OP_LDI:  i_nxt = {4'd0, f_nnn};
          OP_JPV0: pc_nxt = f_nnn + {4'd0, b_r};
          OP_RND: begin
            rf_we    = 1'b1;
            rf_wdata = rnd_r & f_kk;
          end
          OP_DRW: state_nxt = S_SPR_RD;
          OP_KEY: begin
            if (f_kk == KEY_SKP) begin
              if (key_down) pc_nxt = pc_skip;
            end else if (f_kk == KEY_SKNP) begin
              if (!key_down) pc_nxt = pc_skip;
            end else begin
              flt      = 1'b1;
              flt_code = FAULT_INVAL;
            end
          end
          OP_MISC: begin
            case (f_kk)
              F_GETDT: begin
                rf_we    = 1'b1;
                rf_wdata = dt_r;
              end
              F_WKEY: begin
                if (key_any) begin
                  rf_we    = 1'b1;
                  rf_wdata = {4'd0, key_idx};
                end else begin
                  pc_nxt = pc_r;
                end
              end
              F_SETDT: dt_nxt = a_r;
              F_SETST: st_nxt = a_r;
              F_ADDI:  i_nxt = i_r + {8'd0, a_r};
              F_FONT:  i_nxt = {4'd0, font_r} + {10'd0, a_r[3:0], 2'b00} + {12'd0, a_r[3:0]};
              F_BCD, F_STR, F_LDR: state_nxt = S_BLK_RD;
              default: begin
                flt      = 1'b1;
                flt_code = FAULT_INVAL;
              end
            endcase
          end
          default: begin
            flt      = 1'b1;
            flt_code = FAULT_INVAL;
          end
        endcase
        // A faulting instruction leaves all state but the halt latch alone.
        if (flt) begin
          pc_nxt    = pc_r;
          fault_nxt = flt_code;
          halt_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_WRX: begin
        rf_we     = 1'b1;
        rf_waddr  = f_x;
        rf_wdata  = wx_r;
        state_nxt = S_FIN;
      end
      S_STK: begin
        pc_nxt    = stk_q_r;
        sp_nxt    = sp_r - 4'd1;
        state_nxt = S_FIN;
      end
      S_SPR_RD: begin
        // Stop after n rows or at the bottom edge; reads of the next row go out here.
        if (cnt_r == f_n || spr_y >= 6'(SCREEN_H)) begin
          state_nxt = S_SPR_VF;
        end else begin
          state_nxt = S_SPR_WR;
        end
      end
      S_SPR_WR: begin
        frm_we    = 1'b1;
        hit_nxt   = hit_r | (|(frm_rdata & spr_row));
        cnt_nxt   = cnt_r + 4'd1;
        state_nxt = S_SPR_RD;
      end
      S_SPR_VF: begin
        rf_we     = 1'b1;
        rf_waddr  = 4'hF;
        rf_wdata  = {7'd0, hit_r};
        state_nxt = S_FIN;
      end
      S_BLK_RD: begin
        rf_raddr  = cnt_r;
        state_nxt = S_BLK_WR;
      end
      S_BLK_WR: begin
        if (f_kk == F_BCD) begin
          mem_we    = 1'b1;
          mem_wdata = bcd_digit(a_r, cnt_r[1:0]);
        end else if (f_kk == F_STR) begin
          mem_we    = 1'b1;
          mem_wdata = rf_rdata;
        end else begin
          rf_we    = 1'b1;
          rf_waddr = cnt_r;
          rf_wdata = mem_q_r;
        end
        if (cnt_r == blk_last) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = S_BLK_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Shadow copy of VF for the result beat.
    vf_nxt = (rf_we && rf_waddr == 4'hF) ? rf_wdata : vf_r;
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= PC_RESET;
      i_r         <= '0;
      sp_r        <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      vf_r        <= '0;
      halt_r      <= 1'b0;
      font_r      <= FONT_RESET;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      frm_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      i_r     <= i_nxt;
      sp_r    <= sp_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
      vf_r    <= vf_nxt;
      halt_r  <= halt_nxt;
      if (cfg_we) font_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (rf_we) rf_vld_r[rf_waddr] <= 1'b1;
      if (frm_clr) begin
        frm_vld_r <= '0;
      end else if (frm_we) begin
        frm_vld_r[frm_waddr] <= 1'b1;
      end
    end
  end

  // Item fields, operands and result payload.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    op_r    <= op_nxt;
    keys_r  <= keys_nxt;
    rnd_r   <= rnd_nxt;
    maddr_r <= maddr_nxt;
    mbyte_r <= mbyte_nxt;
    row_r   <= row_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    wx_r    <= wx_nxt;
    cnt_r   <= cnt_nxt;
    hit_r   <= hit_nxt;
    rd_r    <= rd_nxt;
    fault_r <= fault_nxt;
    if (out_load) begin
      out_pc_r    <= pc_r;
      out_i_r     <= i_r;
      out_vf_r    <= vf_r;
      out_rd_r    <= rd_r;
      out_fault_r <= fault_r;
      out_halt_r  <= halt_r;
      out_snd_r   <= (st_r != 8'd0);
    end
  end

  // Byte memory.
  always_ff @(posedge clk) begin
    if (mem_we) mem_ram[mem_waddr] <= mem_wdata;
    mem_q_r <= mem_ram[mem_raddr];
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (rf_we) rf_ram[rf_waddr] <= rf_wdata;
    rf_q_r  <= rf_ram[rf_raddr];
    rf_vq_r <= rf_vld_r[rf_raddr] && !(rf_we && rf_waddr == rf_raddr && 1'b0);
  end

  // Display rows.
  always_ff @(posedge clk) begin
    if (frm_we) frm_ram[frm_waddr] <= frm_wdata;
    frm_q_r  <= frm_ram[frm_raddr];
    frm_vq_r <= frm_vld_r[frm_raddr];
  end

  // Return stack.
  always_ff @(posedge clk) begin
    if (stk_we) stk_ram[stk_waddr] <= stk_wdata;
    stk_q_r <= stk_ram[stk_raddr];
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_index_value = out_i_r;
  assign out_flag_value  = out_vf_r;
  assign out_read_value  = out_rd_r;
  assign out_fault_code  = out_fault_r;
  assign out_halted      = out_halt_r;
  assign out_sound_on    = out_snd_r;

  // Checks on the sequencer and the stack.
  `VMX_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt latch cleared without reset")
  `VMX_ASSERT_NOW(a_sp_range, 1'b1, sp_r <= STACK_AW'(STACK_LIMIT), "stack pointer past limit")
  `VMX_ASSERT_NOW(a_fault_halts, out_valid && (out_fault_code != FAULT_NONE), out_halted, "fault without halt")
  `VMX_ASSERT_NOW(a_fin_busy, state_r == S_FIN, in_stall, "input taken while a result is pending")

endmodule

FILE: sim/vm_instruction_execute_core_checker.sv
// Checker for the instruction execute core: predicts each result and compares it.
`timescale 1ns / 1ps

module vm_instruction_execute_core_checker
  import vmx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  input  logic [11:0] in_mem_address,
  input  logic [7:0]  in_mem_byte,
  input  logic [4:0]  in_row_select,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_next_pc,
  input  logic [15:0] out_index_value,
  input  logic [7:0]  out_flag_value,
  input  logic [63:0] out_read_value,
  input  logic [1:0]  out_fault_code,
  input  logic        out_halted,
  input  logic        out_sound_on,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [11:0] pc;
    logic [15:0] idx;
    logic [7:0]  flag;
    logic [63:0] rd;
    logic [1:0]  fault;
    logic        halted;
    logic        snd;
  } core_result_t;

  core_result_t expected_results[$];

  // Shadow copy of the machine state.
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] ret_stack [16];
  int          sp;
  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] frame [SCREEN_H];
  logic [7:0]  delay_t, sound_t;
  logic        halt;
  logic [11:0] font;

  assign pending = expected_results.size();

  // Carries out one instruction word; returns the fault it raises.
  function automatic fault_t run_instruction(logic [15:0] op, logic [15:0] keys,
                                             logic [7:0] rnd);
    logic [3:0]  x, y, n, key;
    logic [7:0]  kk, a, b, bits, hit;
    logic [11:0] npc;
    logic        down, found;
    int          xp, yp;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    a = vreg[x];
    b = vreg[y];
    npc = pc + 12'd2;
    case (op[15:12])
      OP_SYS: begin
        if (kk == SYS_CLS && x == 4'd0) begin
          for (int r = 0; r < SCREEN_H; r++) frame[r] = '0;
        end else if (kk == SYS_RET && x == 4'd0) begin
          if (sp == 0) return FAULT_UNDER;
          sp--;
          npc = ret_stack[sp];
        end else begin
          return FAULT_INVAL;
        end
      end
      OP_JP: npc = op[11:0];
      OP_CALL: begin
        if (sp >= STACK_LIMIT) return FAULT_OVER;
        ret_stack[sp] = npc;
        sp++;
        npc = op[11:0];
      end
      OP_SEB:  if (a == kk) npc += 12'd2;
      OP_SNEB: if (a != kk) npc += 12'd2;
      OP_SER:  if (a == b) npc += 12'd2;
      OP_LDB:  vreg[x] = kk;
      OP_ADDB: vreg[x] = a + kk;
      OP_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = b;
          ALU_OR:  vreg[x] = a | b;
          ALU_AND: vreg[x] = a & b;
          ALU_XOR: vreg[x] = a ^ b;
          ALU_ADD: begin
            vreg[15] = ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'd1 : 8'd0;
            vreg[x] = a + b;
          end
          ALU_SUB: begin
            vreg[15] = (a >= b) ? 8'd1 : 8'd0;
            vreg[x] = a - b;
          end
          ALU_SHR: begin
            vreg[15] = {7'd0, a[0]};
            vreg[x] = a >> 1;
          end
          ALU_SUBN: begin
            vreg[15] = (b >= a) ? 8'd1 : 8'd0;
            vreg[x] = b - a;
          end
          ALU_SHL: begin
            vreg[15] = {7'd0, a[7]};
            vreg[x] = a << 1;
          end
          default: return FAULT_INVAL;
        endcase
      end
      OP_SNER: if (a != b) npc += 12'd2;
      OP_LDI:  ireg = {4'd0, op[11:0]};
      OP_JPV0: npc = op[11:0] + {4'd0, vreg[0]};
      OP_RND:  vreg[x] = rnd & kk;
      OP_DRW: begin
        // Sprite XOR, clipped at the right and bottom edges.
        hit = 8'd0;
        for (int r = 0; r < n; r++) begin
          yp = (a % SCREEN_W) == -1 ? 0 : (b % SCREEN_H) + r;
          if (yp >= SCREEN_H) break;
          bits = mem[12'(ireg + r)];
          for (int c = 0; c < 8; c++) begin
            xp = (a % SCREEN_W) + c;
            if (xp >= SCREEN_W) break;
            if (bits[7 - c]) begin
              if (frame[yp][63 - xp]) hit = 8'd1;
              frame[yp][63 - xp] = ~frame[yp][63 - xp];
            end
          end
        end
        vreg[15] = hit;
      end
      OP_KEY: begin
        down = (a < 8'd16) && keys[a[3:0]];
        if (kk == KEY_SKP) begin
          if (down) npc += 12'd2;
        end else if (kk == KEY_SKNP) begin
          if (!down) npc += 12'd2;
        end else begin
          return FAULT_INVAL;
        end
      end
      default: begin
        case (kk)
          F_GETDT: vreg[x] = delay_t;
          F_WKEY: begin
            found = 1'b0;
            key = 4'd0;
            for (int k = 15; k >= 0; k--) begin
              if (keys[k]) begin
                found = 1'b1;
                key = 4'(k);
              end
            end
            if (found) vreg[x] = {4'd0, key};
            else npc = pc;
          end
          F_SETDT: delay_t = a;
          F_SETST: sound_t = a;
          F_ADDI:  ireg = ireg + {8'd0, a};
          F_FONT:  ireg = {4'd0, font} + 16'(5 * a[3:0]);
          F_BCD: begin
            mem[12'(ireg)]     = a / 8'd100;
            mem[12'(ireg + 1)] = (a / 8'd10) % 8'd10;
            mem[12'(ireg + 2)] = a % 8'd10;
          end
          F_STR: for (int i = 0; i <= x; i++) mem[12'(ireg + i)] = vreg[i];
          F_LDR: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + i)];
          default: return FAULT_INVAL;
        endcase
      end
    endcase
    pc = npc;
    return FAULT_NONE;
  endfunction

  // Works out the result of one accepted input beat.
  function automatic core_result_t predict_result();
    core_result_t res;
    fault_t       f;
    res = '0;
    f = FAULT_NONE;
    case (mode_t'(in_mode))
      MODE_EXEC: begin
        if (!halt) begin
          f = run_instruction(in_opcode, in_keys_down, in_random_byte);
          if (f != FAULT_NONE) halt = 1'b1;
        end
      end
      MODE_MWR: mem[in_mem_address] = in_mem_byte;
      MODE_MRD: res.rd = {56'd0, mem[in_mem_address]};
      default:  res.rd = frame[in_row_select];
    endcase
    res.pc = pc;
    res.idx = ireg;
    res.flag = vreg[15];
    res.fault = f;
    res.halted = halt;
    res.snd = (sound_t != 8'd0);
    return res;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Watch both channels: predict on input beats, compare on result beats.
  always @(posedge clk) begin
    core_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) vreg[i] = 8'd0;
      for (int r = 0; r < SCREEN_H; r++) frame[r] = '0;
      ireg = 16'd0;
      pc = PC_RESET;
      sp = 0;
      delay_t = 8'd0;
      sound_t = 8'd0;
      halt = 1'b0;
      font = FONT_RESET;
      expected_results.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) font = cfg_wdata;
      if (in_valid && !in_stall) expected_results.push_back(predict_result());
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("next_pc", 64'(exp_r.pc), 64'(out_next_pc));
          compare_field("index_value", 64'(exp_r.idx), 64'(out_index_value));
          compare_field("flag_value", 64'(exp_r.flag), 64'(out_flag_value));
          compare_field("read_value", exp_r.rd, out_read_value);
          compare_field("fault_code", 64'(exp_r.fault), 64'(out_fault_code));
          compare_field("halted", 64'(exp_r.halted), 64'(out_halted));
          compare_field("sound_on", 64'(exp_r.snd), 64'(out_sound_on));
        end
      end
    end
  end

endmodule

FILE: sim/tb_vm_instruction_execute_core_top.sv
// Testbench top for the instruction execute core: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_vm_instruction_execute_core_top;
  import vmx_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  logic        in_valid, in_stall;
  logic [1:0]  in_mode;
  logic [15:0] in_opcode, in_keys_down;
  logic [7:0]  in_random_byte, in_mem_byte;
  logic [11:0] in_mem_address;
  logic [4:0]  in_row_select;
  logic        out_valid, out_stall;
  logic [11:0] out_next_pc;
  logic [15:0] out_index_value;
  logic [7:0]  out_flag_value;
  logic [63:0] out_read_value;
  logic [1:0]  out_fault_code;
  logic        out_halted, out_sound_on;

  int fail_count, pending, results_seen;
  int send_idle_pct, recv_stall_pct;
  int call_depth;
  int beats_sent;
  int idle_cycles;

  vm_instruction_execute_core_top uut (.*);

  vm_instruction_execute_core_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one beat; valid stays high across back-to-back beats.
  task automatic send_beat(mode_t mode, logic [15:0] op, logic [15:0] keys, logic [7:0] rnd,
                           logic [11:0] addr, logic [7:0] data, logic [4:0] row);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_opcode <= op;
    in_keys_down <= keys;
    in_random_byte <= rnd;
    in_mem_address <= addr;
    in_mem_byte <= data;
    in_row_select <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic exec_op(logic [15:0] op, logic [15:0] keys = $urandom_range(16'hFFFF));
    send_beat(MODE_EXEC, op, keys, $urandom_range(255), $urandom_range(4095),
              $urandom_range(255), $urandom_range(31));
  endtask

  // Lowers valid and waits until every result is in and the core is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_font(logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A random well-formed instruction that never faults.
  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    logic [3:0]  alu_codes [9];
    logic [7:0]  misc_codes [9];
    alu_codes = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
                  ALU_SHL};
    misc_codes = '{F_GETDT, F_WKEY, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD, F_STR, F_LDR};
    op = $urandom_range(16'hFFFF);
    case (op[15:12])
      OP_SYS: begin
        op[11:8] = 4'd0;
        op[7:0] = (call_depth > 0 && $urandom_range(1)) ? SYS_RET : SYS_CLS;
        if (op[7:0] == SYS_CLS && $urandom_range(3) != 0) op[15:12] = OP_LDB;
      end
      OP_CALL: if (call_depth >= STACK_LIMIT) op[15:12] = OP_JP;
      OP_ALU:  op[3:0] = alu_codes[$urandom_range(8)];
      OP_KEY:  op[7:0] = $urandom_range(1) ? KEY_SKP : KEY_SKNP;
      OP_MISC: op[7:0] = misc_codes[$urandom_range(8)];
      default: ;
    endcase
    if (op[15:12] == OP_CALL) call_depth++;
    if (op[15:12] == OP_SYS && op[7:0] == SYS_RET) call_depth--;
    return op;
  endfunction

  task automatic random_beat();
    int pick;
    logic [15:0] keys;
    pick = $urandom_range(99);
    keys = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(16'hFFFF));
    if (pick < 80) begin
      exec_op(random_opcode(), keys);
    end else begin
      send_beat(pick < 87 ? MODE_MWR : (pick < 93 ? MODE_MRD : MODE_ROW),
                $urandom_range(16'hFFFF), keys, $urandom_range(255), $urandom_range(4095),
                $urandom_range(255), $urandom_range(31));
    end
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    logic [11:0] phase_font [4];
    int fault_kind;
    phase_idle = '{0, 60, 0, 32};
    phase_stall = '{0, 0, 60, 32};
    phase_font = '{12'hFFF, 12'h000, 12'($urandom_range(4095)), FONT_RESET};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_EXEC;
    in_opcode = '0;
    in_keys_down = '0;
    in_random_byte = '0;
    in_mem_address = '0;
    in_mem_byte = '0;
    in_row_select = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    call_depth = 0;
    beats_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every memory byte so no later access reads an unwritten location.
    for (int a = 0; a < MEM_BYTES; a++) begin
      send_beat(MODE_MWR, '0, '0, '0, 12'(a), $urandom_range(255), '0);
    end

    // Directed instructions: field extremes, carries, clipping, keys and stack use.
    exec_op({OP_LDB, 4'h0, 8'hFF});
    exec_op({OP_LDB, 4'h1, 8'h01});
    exec_op({OP_ALU, 4'h0, 4'h1, ALU_ADD});
    exec_op({OP_ALU, 4'h1, 4'h0, ALU_SUB});
    exec_op({OP_ALU, 4'hF, 4'h1, ALU_SUBN});
    exec_op({OP_ALU, 4'h1, 4'h1, ALU_SHL});
    exec_op({OP_ALU, 4'h0, 4'h0, ALU_SHR});
    exec_op({OP_ADDB, 4'h0, 8'hFF});
    exec_op({OP_KEY, 4'h0, KEY_SKP}, 16'hFFFF);
    exec_op({OP_KEY, 4'h0, KEY_SKNP}, 16'hFFFF);
    exec_op({OP_MISC, 4'h2, F_WKEY}, 16'h0000);
    exec_op({OP_MISC, 4'h2, F_WKEY}, 16'h8000);
    exec_op({OP_LDI, 12'hFFF});
    exec_op({OP_MISC, 4'hF, F_STR});
    exec_op({OP_MISC, 4'h0, F_SETST});
    exec_op({OP_MISC, 4'h1, F_FONT});
    exec_op({OP_MISC, 4'hF, F_LDR});
    exec_op({OP_LDB, 4'h3, 8'h3F});
    exec_op({OP_LDB, 4'h4, 8'h1E});
    exec_op({OP_DRW, 4'h3, 4'h4, 4'hF});
    exec_op({OP_DRW, 4'h3, 4'h4, 4'hF});
    exec_op({OP_CALL, 12'hFFE});
    exec_op({OP_SYS, 4'h0, SYS_RET});
    exec_op({OP_JPV0, 12'hFFF});
    send_beat(MODE_ROW, '0, '0, '0, '0, '0, 5'd31);
    drain();

    // Random phases, one font base and one pacing setting each; the core is idle at
    // every font write.
    for (int p = 0; p < 4; p++) begin
      write_font(phase_font[p]);
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 400; i++) begin
        random_beat();
      end
      drain();
    end

    // One fault stops execution for the rest of the run; pick which one at random.
    send_idle_pct = 20;
    recv_stall_pct = 20;
    fault_kind = $urandom_range(2);
    if (fault_kind == 0) begin
      exec_op({OP_ALU, 4'h1, 4'h2, 4'hF});
    end else if (fault_kind == 1) begin
      while (call_depth <= STACK_LIMIT) begin
        exec_op({OP_CALL, 12'($urandom_range(4095))});
        call_depth++;
      end
    end else begin
      while (call_depth >= 0) begin
        exec_op({OP_SYS, 4'h0, SYS_RET});
        call_depth--;
      end
    end
    for (int i = 0; i < 12; i++) begin
      random_beat();
    end
    drain();

    $display("Ran %0d beats through four pacing phases and four font bases,", beats_sent);
    $display("ending with a halting fault; %0d results were checked.", results_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: vm_instruction_execute_core_top.f
+incdir+hw/rtl
hw/rtl/vmx_pkg.sv
hw/rtl/vm_instruction_execute_core_top.sv
sim/vm_instruction_execute_core_checker.sv
sim/tb_vm_instruction_execute_core_top.sv
